### design/rsfr_pkg.sv
// Shared types and constants of the serial RC frame receiver.
`timescale 1ns / 1ps

package rsfr_pkg;

	// Fixed field widths
	localparam int unsigned CHAN_W     = 4;
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned MS_W       = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Frame framing and check constants
	localparam logic [BYTE_W-1:0]  SYNC_FIRST  = 8'h20;
	localparam logic [BYTE_W-1:0]  SYNC_SECOND = 8'h40;
	localparam logic [VALUE_W-1:0] CHECK_BASE  = 16'hFFFF;
	localparam logic [MS_W-1:0]    MS_MAX      = 16'hFFFF;

	// Input kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR_CHANNEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FS_THROTTLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FS_OTHER    = 3'd4;

	// Configuration reset values
	localparam logic [7:0]         GAP_LIMIT_RST   = 8'd10;
	localparam logic [MS_W-1:0]    LOSS_LIMIT_RST  = 16'd1000;
	localparam logic [CHAN_W-1:0]  THR_CHANNEL_RST = 4'd2;
	localparam logic [VALUE_W-1:0] FS_THROTTLE_RST = 16'd1000;
	localparam logic [VALUE_W-1:0] FS_OTHER_RST    = 16'd1500;

	// Controller to datapath commands
	typedef struct packed {
		logic take;        // input transfer this cycle
		logic load_first;  // load channel 0 into the output registers
		logic load_next;   // load the following channel
	} rsfr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic emit;        // accepted item starts a run of channels
		logic last;        // output registers hold the final channel
	} rsfr_stat_t;

endpackage

### design/rsfr_ctrl.sv
// Controller state machine: input acceptance and channel run sequencing.
`timescale 1ns / 1ps

module rsfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsfr_pkg::rsfr_cmd_t  cmd,
	input  rsfr_pkg::rsfr_stat_t stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_SEND
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;

	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

	// Issue datapath commands
	always_comb begin
		cmd.take       = in_valid && !in_stall_q;
		cmd.load_first = (state_q == ST_START);
		cmd.load_next  = (state_q == ST_SEND) && !out_stall && !stat.last;
	end

	// Hold state and handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && stat.emit) begin
						state_q    <= ST_START;
						in_stall_q <= 1'b1;
					end
				end
				ST_START: begin
					state_q     <= ST_SEND;
					out_valid_q <= 1'b1;
				end
				ST_SEND: begin
					if (!out_stall && stat.last) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
						in_stall_q  <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
					in_stall_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

### design/rsfr_datapath.sv
// Datapath: configuration, frame hunt, frame store, check sum and channel output.
`timescale 1ns / 1ps

module rsfr_datapath #(
	parameter int unsigned NUM_CHANNELS = 14,
	parameter int unsigned FRAME_BYTES  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rsfr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                kind,
	input  logic [rsfr_pkg::BYTE_W-1:0]         data_byte,
	input  rsfr_pkg::rsfr_cmd_t                 cmd,
	output rsfr_pkg::rsfr_stat_t                stat,
	output logic [rsfr_pkg::CHAN_W-1:0]         channel_index,
	output logic [rsfr_pkg::VALUE_W-1:0]        channel_value,
	output logic                                signal_lost,
	output logic                                last
);

	localparam int unsigned PW    = $clog2(FRAME_BYTES);
	localparam int unsigned AW    = PW - 1;
	localparam int unsigned WORDS = (FRAME_BYTES + 1) / 2;

	// Configuration registers
	logic [7:0]                     gap_limit_q;
	logic [rsfr_pkg::MS_W-1:0]      loss_limit_q;
	logic [rsfr_pkg::CHAN_W-1:0]    thr_channel_q;
	logic [rsfr_pkg::VALUE_W-1:0]   fs_throttle_q;
	logic [rsfr_pkg::VALUE_W-1:0]   fs_other_q;

	// Receive state
	logic [PW-1:0]                  pos_q;
	logic [rsfr_pkg::MS_W-1:0]      ms_q;
	logic                           lost_q;
	logic [rsfr_pkg::VALUE_W-1:0]   sum_q;
	logic [rsfr_pkg::BYTE_W-1:0]    lo_q;
	logic [1:0][rsfr_pkg::BYTE_W-1:0] frame_mem_q [WORDS];

	// Output registers
	logic [rsfr_pkg::CHAN_W-1:0]    chan_q;
	logic [rsfr_pkg::VALUE_W-1:0]   value_q;
	logic                           run_lost_q;
	logic                           last_q;

	// Hunt and check decisions
	logic [PW-1:0]                  pos_eff;
	logic [rsfr_pkg::MS_W-1:0]      ms_inc;
	logic                           fail_fire;
	logic                           sync_bad;
	logic                           frame_end;
	logic                           frame_pass;

	// Channel selection for the output load
	logic [rsfr_pkg::CHAN_W-1:0]    k_sel;
	logic [4:0]                     word_w;
	logic [5:0]                     byte_lo_w;
	logic [1:0][rsfr_pkg::BYTE_W-1:0] word_rd;
	logic [rsfr_pkg::VALUE_W-1:0]   frame_val;
	logic [rsfr_pkg::VALUE_W-1:0]   fs_val;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q   <= rsfr_pkg::GAP_LIMIT_RST;
			loss_limit_q  <= rsfr_pkg::LOSS_LIMIT_RST;
			thr_channel_q <= rsfr_pkg::THR_CHANNEL_RST;
			fs_throttle_q <= rsfr_pkg::FS_THROTTLE_RST;
			fs_other_q    <= rsfr_pkg::FS_OTHER_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rsfr_pkg::REG_GAP_LIMIT:   gap_limit_q   <= cfg_data[7:0];
				rsfr_pkg::REG_LOSS_LIMIT:  loss_limit_q  <= cfg_data;
				rsfr_pkg::REG_THR_CHANNEL: thr_channel_q <= cfg_data[rsfr_pkg::CHAN_W-1:0];
				rsfr_pkg::REG_FS_THROTTLE: fs_throttle_q <= cfg_data;
				rsfr_pkg::REG_FS_OTHER:    fs_other_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decide gap restart, sync, frame end, check and loss
	always_comb begin
		pos_eff   = (ms_q > {8'd0, gap_limit_q}) ? '0 : pos_q;
		ms_inc    = (ms_q == rsfr_pkg::MS_MAX) ? ms_q : ms_q + 1'b1;
		fail_fire = (kind == rsfr_pkg::KIND_TICK) && (ms_inc > loss_limit_q) && !lost_q;
		sync_bad  = ((pos_eff == '0) && (data_byte != rsfr_pkg::SYNC_FIRST)) ||
		            ((pos_eff == PW'(1)) && (data_byte != rsfr_pkg::SYNC_SECOND));
		frame_end = !sync_bad && (pos_eff == PW'(FRAME_BYTES - 1));
		frame_pass = (kind == rsfr_pkg::KIND_BYTE) && frame_end &&
		             ((rsfr_pkg::CHECK_BASE - sum_q) == {data_byte, lo_q});
		stat.emit = fail_fire || frame_pass;
		stat.last = last_q;
	end

	// Advance position, gap timer and loss flag on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ms_q   <= '0;
			lost_q <= 1'b0;
		end else if (cmd.take) begin
			if (kind == rsfr_pkg::KIND_TICK) begin
				ms_q <= ms_inc;
				if (fail_fire) begin
					lost_q <= 1'b1;
				end
			end else begin
				ms_q <= '0;
				if (sync_bad || frame_end) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_eff + 1'b1;
				end
				if (frame_pass) begin
					lost_q <= 1'b0;
				end
			end
		end
	end

	// Store frame bytes and accumulate the check sum
	always_ff @(posedge clk) begin
		if (cmd.take && (kind == rsfr_pkg::KIND_BYTE) && !sync_bad) begin
			frame_mem_q[pos_eff[PW-1:1]][pos_eff[0]] <= data_byte;
			if (pos_eff == '0) begin
				sum_q <= {8'd0, data_byte};
			end else if (pos_eff < PW'(FRAME_BYTES - 2)) begin
				sum_q <= sum_q + {8'd0, data_byte};
			end
			if (pos_eff == PW'(FRAME_BYTES - 2)) begin
				lo_q <= data_byte;
			end
		end
	end

	// Select the channel to load and its value
	always_comb begin
		k_sel     = cmd.load_first ? '0 : chan_q + 1'b1;
		word_w    = {1'b0, k_sel} + 5'd1;
		byte_lo_w = {1'b0, k_sel, 1'b0} + 6'd2;
		word_rd   = frame_mem_q[word_w[AW-1:0]];
		frame_val = '0;
		if (word_w < 5'(WORDS)) begin
			if (byte_lo_w < 6'(FRAME_BYTES)) begin
				frame_val[7:0] = word_rd[0];
			end
			if ((byte_lo_w + 6'd1) < 6'(FRAME_BYTES)) begin
				frame_val[15:8] = word_rd[1];
			end
		end
		fs_val = (k_sel == thr_channel_q) ? fs_throttle_q : fs_other_q;
	end

	// Record the run kind when a run starts
	always_ff @(posedge clk) begin
		if (cmd.take && stat.emit) begin
			run_lost_q <= (kind == rsfr_pkg::KIND_TICK);
		end
	end

	// Load channel number and last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			last_q <= 1'b0;
		end else if (cmd.load_first || cmd.load_next) begin
			chan_q <= k_sel;
			last_q <= (k_sel == rsfr_pkg::CHAN_W'(NUM_CHANNELS - 1));
		end
	end

	// Load channel value
	always_ff @(posedge clk) begin
		if (cmd.load_first || cmd.load_next) begin
			value_q <= run_lost_q ? fs_val : frame_val;
		end
	end

	assign channel_index = chan_q;
	assign channel_value = value_q;
	assign signal_lost   = run_lost_q;
	assign last          = last_q;

endmodule

### design/rc_serial_frame_receiver.sv
// Top level of the serial RC frame receiver.
`timescale 1ns / 1ps

// Serial RC frame receiver. Each input transfer is a received byte or a
// one millisecond tick. Bytes are hunted for a FRAME_BYTES frame that starts
// 0x20 0x40; a byte gap longer than gap_limit_ms restarts the hunt. A frame
// whose check (0xFFFF minus the 16-bit sum of all but the last two bytes)
// matches the little-endian trailer emits NUM_CHANNELS channel transfers and
// clears signal loss. When more than loss_limit_ms pass without bytes, one
// failsafe run is emitted with signal_lost set. An item that causes no
// result is taken and the next item may follow at once. An item that starts
// a run is accepted, then channel 0 is loaded from the frame store, then the
// channels are shown through the output register, one channel per cycle
// while out_stall is low. in_stall is high during the run and drops after
// the last channel transfer. The frame store needs no clearing after reset.
module rc_serial_frame_receiver #(
	parameter int unsigned NUM_CHANNELS = 14,
	parameter int unsigned FRAME_BYTES  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [rsfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [rsfr_pkg::BYTE_W-1:0]     data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rsfr_pkg::CHAN_W-1:0]     channel_index,
	output logic [rsfr_pkg::VALUE_W-1:0]    channel_value,
	output logic                            signal_lost,
	output logic                            last
);

	rsfr_pkg::rsfr_cmd_t  cmd;
	rsfr_pkg::rsfr_stat_t stat;

	// Sequence acceptance and channel runs
	rsfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Parse frames and form channel values
	rsfr_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.FRAME_BYTES  (FRAME_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.stat          (stat),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.signal_lost   (signal_lost),
		.last          (last)
	);

endmodule
